/* rtl/crct_pkg.sv */
// Package for the Catmull-Rom curve tessellator: widths, constants, state enum.
// No dependencies.
`default_nettype none
package crct_pkg;
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int FRAC_BITS        = 16;
  localparam int CFG_WIDTH        = 7;
  localparam logic [CFG_WIDTH-1:0] SEG_RESET = 7'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIV,
    ST_T2,
    ST_T3,
    ST_COEF,
    ST_MULB,
    ST_MULC,
    ST_MULD,
    ST_SUM,
    ST_OUT,
    ST_POLY
  } state_t;
endpackage
`default_nettype wire

/* rtl/crct_if.sv */
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface crct_if #(parameter int W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/catmull_rom_curve_tessellator.sv */
// Top level of the Catmull-Rom curve tessellator.
// Depends on crct_pkg and crct_if.
`default_nettype none
// Takes one control point per transfer (in_ channel data: {path_end, z, y, x}) and
// emits line segments on out_ (data: {last_of_run, end z, y, x, start z, y, x}).
// A point that closes a span yields N segments. Each segment runs a bit-serial divide
// for t (ST_TDIV), then ST_T2, ST_T3 and ST_COEF for t^2, t^3 and the coefficients,
// then ST_MULB, ST_MULC, ST_MULD and ST_SUM per axis on one shared multiplier, then
// ST_OUT, which waits while the previous segment is still held on out_ by a stall.
// The block takes no new point until all segments of the current one are out.
module catmull_rom_curve_tessellator
  import crct_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CFG_WIDTH-1:0] cfg_wdata,
  crct_if.sink                in_ch,
  crct_if.source              out_ch
);
  localparam int CW = COORD_WIDTH;
  localparam int TW = FRAC_BITS + 1;
  localparam int KW = CW + 4;          // coefficient width
  localparam int PW = KW + TW;         // product width
  localparam int SW = PW + 2;          // sum width
  localparam int JW = $clog2(MAX_SEGMENTS + 1) + 1;
  localparam int DW = JW + FRAC_BITS;  // dividend width

  typedef logic signed [CW-1:0] crd_t;

  state_t state_r, state_nxt;
  logic [CFG_WIDTH-1:0] seg_r;
  crd_t win_r [3][3];
  crd_t cur_r [3];
  crd_t prev_r [3];
  crd_t smp_r [3];
  logic [1:0] seen_r;
  logic end_r;
  logic [JW-1:0] n_r, j_r;
  logic [DW-1:0] quo_r, rem_r;
  logic [4:0] bit_r;
  logic [TW-1:0] t_r, t2_r, t3_r;
  logic signed [KW-1:0] kb_r [3], kc_r [3], kd_r [3];
  logic signed [PW-1:0] pb_r, pc_r, pd_r;
  logic [1:0] ax_r;
  logic poly_r;
  logic [6*CW:0] od_r;
  logic ov_r;

  // shared multiplier
  logic signed [KW-1:0] ma;
  logic [TW-1:0] mb;
  logic signed [PW-1:0] mp;
  always_comb begin
    ma = '0;
    mb = t_r;
    unique case (state_r)
      ST_T2:   begin ma = KW'(signed'({1'b0, TW'(quo_r)})); mb = TW'(quo_r); end
      ST_T3:   begin ma = KW'(signed'({1'b0, t2_r})); mb = t_r; end
      ST_MULB: begin ma = kb_r[ax_r]; mb = t_r; end
      ST_MULC: begin ma = kc_r[ax_r]; mb = t2_r; end
      ST_MULD: begin ma = kd_r[ax_r]; mb = t3_r; end
      default: ma = '0;
    endcase
    mp = ma * signed'({1'b0, mb});
  end

  logic [JW-1:0] n_eff;
  always_comb begin
    if (seg_r == '0) n_eff = JW'(1);
    else if (32'(seg_r) > MAX_SEGMENTS) n_eff = JW'(MAX_SEGMENTS);
    else n_eff = JW'(seg_r);
  end

  logic [DW:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[DW-1]};

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] half;
  crd_t sat;
  always_comb begin
    sum = (SW'(win_r[ax_r][1]) <<< 1) + SW'(pb_r >>> FRAC_BITS)
        + SW'(pc_r >>> FRAC_BITS) + SW'(pd_r >>> FRAC_BITS);
    half = sum >>> 1;
    if (half > SW'(crd_t'({1'b0, {(CW-1){1'b1}}}))) sat = {1'b0, {(CW-1){1'b1}}};
    else if (half < -SW'(crd_t'({1'b0, {(CW-1){1'b1}}})) - SW'(1)) sat = {1'b1, {(CW-1){1'b0}}};
    else sat = crd_t'(half);
  end

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (seen_r == 2'd3) state_nxt = ST_TDIV;
        else if (in_ch.data[3*CW] && seen_r != 2'd0) state_nxt = ST_POLY;
      end
      ST_TDIV: if (bit_r == 5'(DW - 1)) state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_T3;
      ST_T3:   state_nxt = ST_COEF;
      ST_COEF: state_nxt = ST_MULB;
      ST_MULB: state_nxt = ST_MULC;
      ST_MULC: state_nxt = ST_MULD;
      ST_MULD: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = (ax_r == 2'd2) ? ST_OUT : ST_MULB;
      ST_OUT:  if (!ov_r) state_nxt = (j_r == n_r) ? ST_IDLE : ST_TDIV;
      ST_POLY: if (!ov_r && poly_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET;
      seen_r <= '0;
      ov_r <= 1'b0;
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 3; k++) win_r[a][k] <= '0;
    end else begin
      if (cfg_we) seg_r <= cfg_wdata;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (acc) begin
          for (int a = 0; a < 3; a++) cur_r[a] <= crd_t'(in_ch.data[a*CW +: CW]);
          end_r <= in_ch.data[3*CW];
          n_r <= n_eff;
          j_r <= JW'(1);
          poly_r <= (seen_r == 2'd1);
          for (int a = 0; a < 3; a++) prev_r[a] <= win_r[a][1];
          quo_r <= DW'(1) << FRAC_BITS;
          rem_r <= '0;
          bit_r <= '0;
        end
        ST_TDIV: begin
          bit_r <= bit_r + 5'd1;
          if (rem_sh >= (DW+1)'(n_r)) begin
            rem_r <= DW'(rem_sh - (DW+1)'(n_r));
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= DW'(rem_sh);
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
        end
        ST_T2: begin
          t_r <= TW'(quo_r);
          t2_r <= TW'(mp >>> FRAC_BITS);
          ax_r <= '0;
        end
        ST_T3: t3_r <= TW'(mp >>> FRAC_BITS);
        ST_COEF: begin
          for (int a = 0; a < 3; a++) begin
            kb_r[a] <= KW'(win_r[a][2]) - KW'(win_r[a][0]);
            kc_r[a] <= (KW'(win_r[a][0]) <<< 1) - KW'(win_r[a][1]) * 5
                     + (KW'(win_r[a][2]) <<< 2) - KW'(cur_r[a]);
            kd_r[a] <= KW'(win_r[a][1]) * 3 - KW'(win_r[a][2]) * 3
                     + KW'(cur_r[a]) - KW'(win_r[a][0]);
          end
        end
        ST_MULB: pb_r <= mp;
        ST_MULC: pc_r <= mp;
        ST_MULD: pd_r <= mp;
        ST_SUM: begin
          smp_r[ax_r] <= sat;
          ax_r <= ax_r + 2'd1;
        end
        ST_OUT: if (!ov_r) begin
          ov_r <= 1'b1;
          od_r <= {j_r == n_r, smp_r[2], smp_r[1], smp_r[0],
                   prev_r[2], prev_r[1], prev_r[0]};
          for (int a = 0; a < 3; a++) prev_r[a] <= smp_r[a];
          j_r <= j_r + JW'(1);
          quo_r <= DW'(j_r + JW'(1)) << FRAC_BITS;
          rem_r <= '0;
          bit_r <= '0;
        end
        ST_POLY: if (!ov_r) begin
          ov_r <= 1'b1;
          if (poly_r)
            od_r <= {1'b1, cur_r[2], cur_r[1], cur_r[0],
                     win_r[2][2], win_r[1][2], win_r[0][2]};
          else
            od_r <= {1'b0, win_r[2][2], win_r[1][2], win_r[0][2],
                     win_r[2][1], win_r[1][1], win_r[0][1]};
          poly_r <= 1'b1;
        end
        default: ;
      endcase
      if (state_r != ST_IDLE && state_nxt == ST_IDLE) begin
        for (int a = 0; a < 3; a++) begin
          win_r[a][0] <= win_r[a][1];
          win_r[a][1] <= win_r[a][2];
          win_r[a][2] <= cur_r[a];
        end
        if (end_r) seen_r <= '0;
        else if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
      end
      if (state_r == ST_IDLE && acc && state_nxt == ST_IDLE) begin
        for (int a = 0; a < 3; a++) begin
          win_r[a][0] <= win_r[a][1];
          win_r[a][1] <= win_r[a][2];
          win_r[a][2] <= crd_t'(in_ch.data[a*CW +: CW]);
        end
        if (in_ch.data[3*CW]) seen_r <= '0;
        else if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire
